[hdl/cpe_pkg.sv]
package cpe_pkg;

  localparam int unsigned NumSteps = 16;

  // Q16.16 plant constants
  localparam logic signed [31:0] QGravity     = 32'sd642253;
  localparam logic signed [31:0] QPml         = 32'sd3277;
  localparam logic signed [31:0] QInvTm       = 32'sd59578;
  localparam logic signed [31:0] QMpTm        = 32'sd5958;
  localparam logic signed [31:0] QHalfLen     = 32'sd32768;
  localparam logic signed [31:0] QFourThirds  = 32'sd87381;
  localparam logic signed [31:0] QPmlTm       = 32'sd2979;
  localparam logic signed [31:0] QXBand       = 32'sd52429;
  localparam logic signed [31:0] QXdBand      = 32'sd32768;
  localparam logic signed [31:0] QOneDeg      = 32'sd1144;
  localparam logic signed [31:0] QSixDeg      = 32'sd6863;
  localparam logic signed [31:0] QFiftyDeg    = 32'sd57191;
  localparam logic signed [31:0] QPi          = 32'sd205887;
  localparam logic signed [31:0] QHalfPi      = 32'sd102944;
  localparam logic signed [31:0] QTwoPi       = 32'sd411775;
  localparam logic signed [31:0] QCordicK     = 32'sd39797;

  // register indexes
  localparam logic [1:0] RegForce    = 2'd0;
  localparam logic [1:0] RegTimeStep = 2'd1;
  localparam logic [1:0] RegPosLimit = 2'd2;
  localparam logic [1:0] RegAngLimit = 2'd3;

  localparam logic CmdStep  = 1'b0;
  localparam logic CmdReset = 1'b1;

  // arctangent table, Q16.16
  function automatic logic signed [31:0] atan_lut(input logic [3:0] idx);
    logic signed [31:0] v;
    case (idx)
      4'd0:  v = 32'sd51472;
      4'd1:  v = 32'sd30386;
      4'd2:  v = 32'sd16055;
      4'd3:  v = 32'sd8150;
      4'd4:  v = 32'sd4091;
      4'd5:  v = 32'sd2047;
      4'd6:  v = 32'sd1024;
      4'd7:  v = 32'sd512;
      4'd8:  v = 32'sd256;
      4'd9:  v = 32'sd128;
      4'd10: v = 32'sd64;
      4'd11: v = 32'sd32;
      4'd12: v = 32'sd16;
      4'd13: v = 32'sd8;
      4'd14: v = 32'sd4;
      default: v = 32'sd2;
    endcase
    return v;
  endfunction

  // truncating (toward zero) shift right of a signed value
  function automatic logic signed [31:0] tshr(input logic signed [31:0] v,
                                              input logic [3:0] sh);
    logic signed [31:0] a;
    a = (v < 0) ? -v : v;
    a = a >>> sh;
    return (v < 0) ? -a : a;
  endfunction

  typedef enum logic [4:0] {
    StIdle, StRed0, StRed1, StRed2, StCordic, StFold,
    StM0, StM1, StM2, StT0, StT1, StN0, StN1, StN2,
    StD0, StD1, StD2, StD3, StDiv, StX0, StX1,
    StU0, StU1, StU2, StU3, StOut
  } state_e;

  // operand pair to the shared multiplier
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

endpackage

[hdl/cpe_qmul.sv]
module cpe_qmul
  import cpe_pkg::*;
#(
  parameter int unsigned EffW = 32
) (
  input  mul_req_t           req_i,
  output logic signed [31:0] prod_o
);
  logic signed [63:0] full;
  logic signed [63:0] q;
  logic signed [63:0] hi;
  logic signed [63:0] lo;

  // exact product, truncate toward zero by 2^16, saturate
  always_comb begin
    full = 64'(req_i.a) * 64'(req_i.b);
    q = (full < 0) ? -((-full) >>> 16) : (full >>> 16);
    hi = (64'sd1 <<< (EffW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (q > hi) prod_o = hi[31:0];
    else if (q < lo) prod_o = lo[31:0];
    else prod_o = q[31:0];
  end
endmodule

[hdl/cpe_divider.sv]
module cpe_divider
  import cpe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic        [48:0] quot_o,
  output logic               neg_o
);
  logic [48:0] dvd_q, dvd_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q, neg_d;
  logic [32:0] trial;
  logic [31:0] an;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    dvd_d = dvd_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_o = 1'b0;
    an = num_i[31] ? 32'(-num_i) : num_i;
    trial = {rem_q[31:0], dvd_q[48]} - {1'b0, den_q};
    if (start_i) begin
      dvd_d = {an, 17'd0} >> 1;
      den_d = den_i;
      rem_d = '0;
      cnt_d = 6'd49;
      busy_d = 1'b1;
      neg_d = num_i[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        dvd_d = {dvd_q[47:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], dvd_q[48]};
        dvd_d = {dvd_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d; den_q <= den_d; rem_q <= rem_d; neg_q <= neg_d;
  end

  assign quot_o = dvd_q;
  assign neg_o = neg_q;
endmodule

[hdl/cart_pole_euler_step_top.sv]
// A step command runs angle reduction, 16 CORDIC iterations, a bit-serial divide and a
//   sequence of multiply/add steps on the shared multiplier before out_valid_o; a reset
//   command goes straight to the output stage.
// A new command is taken only once the last one has left the sequencer.
// Input stall is high while a command is in work or its result waits behind an unread one.
// rst_ni (async, active low) zeroes the plant state and loads register defaults.
module cart_pole_euler_step_top
  import cpe_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic               push_right_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_position_o,
  output logic signed [31:0] new_velocity_o,
  output logic signed [31:0] new_angle_o,
  output logic signed [31:0] new_angular_rate_o,
  output logic [7:0]         region_index_o,
  output logic               failed_o
);
  localparam int unsigned EffW = (WORD_WIDTH > 32) ? 32 : ((WORD_WIDTH < 24) ? 24 : WORD_WIDTH);
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (EffW - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;
  // 2pi << 12 still fits 32 bits; |angle| / 2pi stays below 2^13
  localparam logic [3:0] RedTop = 4'd12;

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > SatHi) return SatHi[31:0];
    if (v < SatLo) return SatLo[31:0];
    return v[31:0];
  endfunction

  state_e state_q, state_d;
  logic [30:0] force_q, plim_q, alim_q;
  logic [16:0] dt_q;
  logic signed [31:0] pos_q, vel_q, ang_q, rate_q;
  logic signed [31:0] pos_d, vel_d, ang_d, rate_d;
  logic signed [31:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic signed [31:0] s_q, c_q, s_d, c_d;
  logic signed [31:0] t0_q, t1_q, t2_q, t0_d, t1_d, t2_d;
  logic [31:0] red_q, red_d;
  logic [31:0] red_sub;
  logic [3:0] it_q, it_d;
  logic negc_q, negc_d, right_q, right_d;
  logic out_v_q, out_v_d;
  logic load_out;
  logic signed [31:0] opos_q, ovel_q, oang_q, orate_q;
  logic [7:0] oreg_q;
  logic ofail_q;
  mul_req_t mreq;
  logic signed [31:0] mp;
  logic div_start, div_done, div_neg;
  logic [48:0] div_quot;
  logic signed [31:0] fneg;
  logic signed [31:0] tacc;
  logic [48:0] qlim;
  logic signed [31:0] r;
  logic signed [31:0] dtv;
  logic signed [31:0] den;

  cpe_qmul #(.EffW(EffW)) u_mul (.req_i(mreq), .prod_o(mp));

  cpe_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(t0_q), .den_i(den),
    .done_o(div_done), .quot_o(div_quot), .neg_o(div_neg)
  );

  assign dtv = {15'd0, dt_q};
  assign fneg = right_q ? {1'b0, force_q} : -{1'b0, force_q};
  assign den = (t1_q <= 0) ? 32'sd1 : t1_q;
  assign in_stall_o = (state_q != StIdle);
  assign red_sub = {1'b0, QTwoPi[30:0]} << it_q;

  // saturate the divider quotient
  always_comb begin
    qlim = SatHi[48:0];
    if (div_neg) begin
      tacc = (div_quot > qlim + 49'd1) ? SatLo[31:0] : 32'(-div_quot);
    end else begin
      tacc = (div_quot > qlim) ? SatHi[31:0] : div_quot[31:0];
    end
  end

  // sequencer: every multiply goes through the shared unit
  always_comb begin
    state_d = state_q; x_d = x_q; y_d = y_q; z_d = z_q; s_d = s_q; c_d = c_q;
    t0_d = t0_q; t1_d = t1_q; t2_d = t2_q; it_d = it_q; negc_d = negc_q;
    right_d = right_q; pos_d = pos_q; vel_d = vel_q; ang_d = ang_q;
    rate_d = rate_q; out_v_d = out_v_q && out_stall_i; red_d = red_q;
    mreq = '{a: rate_q, b: rate_q}; div_start = 1'b0; r = z_q; load_out = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          right_d = push_right_i;
          if (command_i == CmdReset) begin
            pos_d = '0; vel_d = '0; ang_d = '0; rate_d = '0;
            state_d = StOut;
          end else begin
            z_d = ang_q;
            red_d = ang_q[31] ? 32'(-ang_q) : ang_q;
            it_d = RedTop;
            state_d = StRed0;
          end
        end
      end
      StRed0: begin
        // |ang| mod 2pi, one compare and subtract of 2pi << it per cycle
        if (red_q >= red_sub) red_d = red_q - red_sub;
        it_d = it_q - 4'd1;
        if (it_q == 4'd0) state_d = StRed1;
      end
      StRed1: begin
        r = $signed(red_q);
        if (z_q[31]) r = -r;
        if (r < 0) r = r + QTwoPi;
        if (r > QPi) r = r - QTwoPi;
        negc_d = 1'b0;
        if (r > QHalfPi) begin r = QPi - r; negc_d = 1'b1; end
        else if (r < -QHalfPi) begin r = -QPi - r; negc_d = 1'b1; end
        z_d = r; x_d = QCordicK; y_d = '0; it_d = '0;
        state_d = StCordic;
      end
      StCordic: begin
        if (z_q >= 0) begin
          x_d = x_q - tshr(y_q, it_q); y_d = y_q + tshr(x_q, it_q);
          z_d = z_q - atan_lut(it_q);
        end else begin
          x_d = x_q + tshr(y_q, it_q); y_d = y_q - tshr(x_q, it_q);
          z_d = z_q + atan_lut(it_q);
        end
        it_d = it_q + 4'd1;
        if (it_q == 4'(NumSteps - 1)) state_d = StFold;
      end
      StFold: begin
        s_d = y_q; c_d = negc_q ? -x_q : x_q;
        state_d = StM0;
      end
      StM0: begin mreq = '{a: rate_q, b: rate_q}; t0_d = mp; state_d = StM1; end
      StM1: begin mreq = '{a: QPml, b: t0_q}; t0_d = mp; state_d = StM2; end
      StM2: begin mreq = '{a: t0_q, b: s_q}; t0_d = mp; state_d = StT0; end
      StT0: begin
        mreq = '{a: sat(64'(fneg) + 64'(t0_q)), b: QInvTm}; t2_d = mp;
        state_d = StN0;
      end
      StN0: begin mreq = '{a: QGravity, b: s_q}; t0_d = mp; state_d = StN1; end
      StN1: begin mreq = '{a: c_q, b: t2_q}; t1_d = mp; state_d = StN2; end
      StN2: begin t0_d = sat(64'(t0_q) - 64'(t1_q)); state_d = StD0; end
      StD0: begin mreq = '{a: c_q, b: c_q}; t1_d = mp; state_d = StD1; end
      StD1: begin mreq = '{a: QMpTm, b: t1_q}; t1_d = mp; state_d = StD2; end
      StD2: begin
        mreq = '{a: QHalfLen, b: sat(64'(QFourThirds) - 64'(t1_q))}; t1_d = mp;
        state_d = StD3;
      end
      StD3: begin div_start = 1'b1; state_d = StDiv; end
      StDiv: begin
        if (div_done) state_d = StT1;
      end
      StT1: begin
        t1_d = tacc;
        state_d = StX0;
      end
      StX0: begin mreq = '{a: QPmlTm, b: t1_q}; x_d = mp; state_d = StX1; end
      StX1: begin
        mreq = '{a: x_q, b: c_q};
        y_d = sat(64'(t2_q) - 64'(mp));
        state_d = StU0;
      end
      StU0: begin
        mreq = '{a: dtv, b: vel_q}; pos_d = sat(64'(pos_q) + 64'(mp));
        state_d = StU1;
      end
      StU1: begin
        mreq = '{a: dtv, b: y_q}; vel_d = sat(64'(vel_q) + 64'(mp));
        state_d = StU2;
      end
      StU2: begin
        mreq = '{a: dtv, b: rate_q}; ang_d = sat(64'(ang_q) + 64'(mp));
        state_d = StU3;
      end
      StU3: begin
        mreq = '{a: dtv, b: t1_q}; rate_d = sat(64'(rate_q) + 64'(mp));
        state_d = StOut;
      end
      StOut: begin
        // wait here while an earlier result is still unread
        if (!out_v_q || !out_stall_i) begin
          out_v_d = 1'b1;
          load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; out_v_q <= 1'b0;
      pos_q <= '0; vel_q <= '0; ang_q <= '0; rate_q <= '0;
      force_q <= 31'd655360; dt_q <= 17'd1311;
      plim_q <= 31'd157286; alim_q <= 31'd13726;
    end else begin
      state_q <= state_d; out_v_q <= out_v_d;
      pos_q <= pos_d; vel_q <= vel_d; ang_q <= ang_d; rate_q <= rate_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegForce:    force_q <= cfg_data_i;
          RegTimeStep: dt_q <= cfg_data_i[16:0];
          RegPosLimit: plim_q <= cfg_data_i;
          RegAngLimit: alim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; s_q <= s_d; c_q <= c_d;
    t0_q <= t0_d; t1_q <= t1_d; t2_q <= t2_d; it_q <= it_d;
    negc_q <= negc_d; right_q <= right_d; red_q <= red_d;
  end

  // result: failure test and box index from the held state
  logic signed [32:0] pl, al;
  logic [7:0] box;
  logic fail_c;
  logic [7:0] region_c;
  always_comb begin
    pl = {2'b0, plim_q}; al = {2'b0, alim_q};
    fail_c = (33'(pos_q) < -pl) || (33'(pos_q) > pl) ||
             (33'(ang_q) < -al) || (33'(ang_q) > al);
    box = 8'd0;
    if (pos_q >= -QXBand) box = (pos_q < QXBand) ? 8'd1 : 8'd2;
    if (vel_q >= -QXdBand) box = box + ((vel_q < QXdBand) ? 8'd3 : 8'd6);
    if (ang_q >= QSixDeg) box = box + 8'd45;
    else if (ang_q >= QOneDeg) box = box + 8'd36;
    else if (ang_q >= 0) box = box + 8'd27;
    else if (ang_q >= -QOneDeg) box = box + 8'd18;
    else if (ang_q >= -QSixDeg) box = box + 8'd9;
    if (rate_q >= -QFiftyDeg) box = box + ((rate_q < QFiftyDeg) ? 8'd54 : 8'd108);
    region_c = fail_c ? 8'd0 : box;
  end

  // output register, loaded when a result leaves the sequencer
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      opos_q <= pos_q; ovel_q <= vel_q; oang_q <= ang_q; orate_q <= rate_q;
      oreg_q <= region_c; ofail_q <= fail_c;
    end
  end

  assign out_valid_o = out_v_q;
  assign new_position_o = opos_q;
  assign new_velocity_o = ovel_q;
  assign new_angle_o = oang_q;
  assign new_angular_rate_o = orate_q;
  assign region_index_o = oreg_q;
  assign failed_o = ofail_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(new_position_o)))
    else $error("result dropped");
  a_state_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> ($stable(new_angle_o) || !$past(out_stall_i)))
    else $error("state moved under result");
`endif
endmodule
